FILE: src/page_framebuffer_refresh_macros.svh
// Assertion macros for the page framebuffer refresh block.
`ifndef PAGE_FRAMEBUFFER_REFRESH_MACROS_SVH
`define PAGE_FRAMEBUFFER_REFRESH_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pfr_pkg.sv
// Constants and types shared by the page framebuffer refresh block.
`default_nettype none

package pfr_pkg;

  localparam int PAGES      = 8;
  localparam int COLUMNS    = 128;
  localparam int HEADER_LEN = 3;
  localparam int DEPTH      = PAGES * COLUMNS;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PAGE_W     = 3;
  localparam int COL_W      = 7;
  localparam int STEP_W     = $clog2(HEADER_LEN + COLUMNS + 1);

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;

  localparam logic [STEP_W-1:0] STEP_PAGE_SEL = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_COL_HIGH = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_COL_LOW  = STEP_W'(2);

  typedef enum logic [0:0] {
    OP_DRAW    = 1'b0,
    OP_REFRESH = 1'b1
  } op_e;

  // Item held in the second stage while the memory read completes.
  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic              pixel_on;
    logic              wr_ok;
    logic              is_data;
    logic [7:0]        cmd_byte;
    logic              frame_end;
  } s1_t;

endpackage

`default_nettype wire

FILE: src/page_framebuffer_refresh.sv
// Page framebuffer with byte-serial refresh stream: top level.
//
// Usage: the slave word carries one item. tuser selects the kind: draw sets
// or clears one pixel (column x, row y, page y/8, bit y%8) and produces no
// output word; refresh emits the next byte of the endless panel stream.
// Per page the stream is three command bytes (0xB0+page, 0x10, 0x00) and
// then the 128 data bytes of that page; tlast marks the last data byte of
// the last page, then the stream wraps to page 0.
// A refresh word passes the second stage, where the memory read lands,
// and then the output register before it shows on the master side.
// Throughput: one item per cycle unless the output stalls, set by the one
// read and one write per cycle of the frame memory and its registered read;
// a draw reads at accept and writes back in the next cycle, and a read that
// overlaps the write to the same byte takes the written value by forwarding.
// Reset: position goes to page 0, step 0, and a clearing pass writes zero
// to all 1024 bytes, one per cycle; tready stays low until the pass ends.
// Stall: a finished byte waits in the output register; the next item is
// still accepted unless a refresh byte sits in the second stage behind a
// full, stalled output register.
`default_nettype none
`include "page_framebuffer_refresh_macros.svh"

module page_framebuffer_refresh
  import pfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // x [6:0], y [12:7], pixel_on [13], zero pad
  input  wire logic        s_axis_tuser,  // op: draw or refresh
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte [7:0]
  output logic             m_axis_tuser,  // is_data
  output logic             m_axis_tlast   // frame_end
);

  // Frame memory, one read port and one write port, registered read.
  logic [7:0]        mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data_q;

  // Clearing pass after reset.
  logic              clr_done_q, clr_done_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  // Refresh position.
  logic [PAGE_W-1:0] page_q, page_d;
  logic [STEP_W-1:0] step_q, step_d;

  // Second stage and forwarding.
  logic       s1_valid_q, s1_valid_d;
  s1_t        s1_q, s1_d;
  logic       fwd_hit_q;
  logic [7:0] fwd_data_q;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_is_data_q, out_fend_q;

  logic accept, s1_adv, out_load;
  op_e  in_op;
  logic [6:0] in_x;
  logic [5:0] in_y;
  logic       in_on;

  logic [PAGE_W-1:0] page_eff, page_inc;
  logic [STEP_W-1:0] step_eff;
  logic [COL_W-1:0]  col;
  logic [7:0]        cur_byte;

  assign in_op = op_e'(s_axis_tuser);
  assign in_x  = s_axis_tdata[6:0];
  assign in_y  = s_axis_tdata[12:7];
  assign in_on = s_axis_tdata[13];

  // Stage 1 moves on unless a refresh byte meets a full, stalled output.
  assign s1_adv        = (s1_q.op == OP_DRAW) || !out_valid_q || m_axis_tready;
  assign s_axis_tready = clr_done_q && (!s1_valid_q || s1_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = s1_valid_q && (s1_q.op == OP_REFRESH) && s1_adv;

  // Normalize the position, then pick the command byte or data column.
  always_comb begin
    page_eff = page_q;
    step_eff = step_q;
    if (32'(page_q) >= PAGES) begin
      page_eff = '0;
    end
    if (32'(step_q) >= HEADER_LEN + COLUMNS) begin
      step_eff = '0;
      page_eff = (32'(page_eff) + 1 >= PAGES) ? '0 : PAGE_W'(32'(page_eff) + 1);
    end
    col = COL_W'(32'(step_eff) - HEADER_LEN);
  end

  // Advance the position after a refresh item.
  always_comb begin
    page_inc = (32'(page_eff) + 1 >= PAGES) ? '0 : PAGE_W'(32'(page_eff) + 1);
    page_d   = page_q;
    step_d   = step_q;
    if (accept && in_op == OP_REFRESH) begin
      if (32'(step_eff) + 1 >= HEADER_LEN + COLUMNS) begin
        step_d = '0;
        page_d = page_inc;
      end else begin
        step_d = STEP_W'(32'(step_eff) + 1);
        page_d = page_eff;
      end
    end
  end

  // Build the stage 1 item and the read address.
  always_comb begin
    s1_d = s1_q;
    rd_addr = '0;
    unique case (in_op)
      OP_DRAW: begin
        rd_addr = ADDR_W'(32'(in_y[5:3]) * COLUMNS + 32'(in_x));
      end
      OP_REFRESH: begin
        rd_addr = ADDR_W'(32'(page_eff) * COLUMNS + 32'(col));
      end
      default: begin
        rd_addr = '0;
      end
    endcase
    if (accept) begin
      s1_d.op        = in_op;
      s1_d.addr      = rd_addr;
      s1_d.mask      = 8'(1) << in_y[2:0];
      s1_d.pixel_on  = in_on;
      s1_d.wr_ok     = (32'(in_x) < COLUMNS) && (32'(in_y[5:3]) < PAGES);
      s1_d.is_data   = 1'b0;
      s1_d.frame_end = 1'b0;
      priority case (step_eff)
        STEP_PAGE_SEL: s1_d.cmd_byte = CMD_PAGE_BASE + 8'(page_eff);
        STEP_COL_HIGH: s1_d.cmd_byte = CMD_COL_HIGH;
        STEP_COL_LOW:  s1_d.cmd_byte = CMD_COL_LOW;
        default: begin
          s1_d.cmd_byte  = CMD_COL_LOW;
          s1_d.is_data   = 1'b1;
          s1_d.frame_end = (32'(col) == COLUMNS - 1) && (32'(page_eff) == PAGES - 1);
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // Take the byte just written when the read raced the write.
  assign cur_byte = fwd_hit_q ? fwd_data_q : rd_data_q;

  // Write port: clearing pass first, then draw write-back.
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_done_d = clr_done_q;
    mem_we     = 1'b0;
    mem_waddr  = s1_q.addr;
    mem_wdata  = s1_q.pixel_on ? (cur_byte | s1_q.mask) : (cur_byte & ~s1_q.mask);
    if (!clr_done_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
        clr_done_d = 1'b1;
      end
    end else if (s1_valid_q && s1_q.op == OP_DRAW && s1_q.wr_ok) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q  <= mem[rd_addr];
      fwd_hit_q  <= mem_we && (mem_waddr == rd_addr);
      fwd_data_q <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_done_q  <= 1'b0;
      clr_cnt_q   <= '0;
      page_q      <= '0;
      step_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_done_q  <= clr_done_d;
      clr_cnt_q   <= clr_cnt_d;
      page_q      <= page_d;
      step_q      <= step_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    if (out_load) begin
      out_byte_q    <= s1_q.is_data ? cur_byte : s1_q.cmd_byte;
      out_is_data_q <= s1_q.is_data;
      out_fend_q    <= s1_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_is_data_q;
  assign m_axis_tlast  = out_fend_q;

  // Hold the slave side off during the clearing pass.
  `PFR_ASSERT_SAME(a_no_accept_clearing, clk_i, rst_ni, !clr_done_q, !s_axis_tready, "accept during clear")
  // Never have an item in stage 1 before clearing ends.
  `PFR_ASSERT_SAME(a_s1_after_clear, clk_i, rst_ni, s1_valid_q, clr_done_q, "stage 1 busy during clear")
  // Mark frame end only on data bytes.
  `PFR_ASSERT_SAME(a_fend_data, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "frame end on command")
  // An accepted refresh must show up as a refresh item in stage 1.
  `PFR_ASSERT_NEXT(a_refresh_stage, clk_i, rst_ni, accept && in_op == OP_REFRESH, s1_valid_q && s1_q.op == OP_REFRESH, "refresh lost in stage 1")

endmodule

`default_nettype wire

FILE: tb/sv/pfr_stream_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the page framebuffer refresh block: shadow store, byte prediction and compare.
module pfr_stream_scoreboard
  import pfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // x [6:0], y [12:7], pixel_on [13], zero pad
  input  logic        s_axis_tuser,   // op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // out_byte [7:0]
  input  logic        m_axis_tuser,   // is_data
  input  logic        m_axis_tlast,   // frame_end
  output int          mismatch_cnt_o,
  output int          pending_cnt_o
);

  typedef struct packed {
    logic       is_data;
    logic [7:0] out_byte;
    logic       frame_end;
  } panel_byte_t;

  logic [7:0]        shadow_store [DEPTH];
  logic [PAGE_W-1:0] shadow_page;
  logic [STEP_W-1:0] shadow_step;
  panel_byte_t       panel_bytes_due [$];
  int                mismatches;

  // Next byte of the panel stream at the shadow position, then advance the position.
  function automatic panel_byte_t next_panel_byte();
    panel_byte_t b;
    int          col;
    b = '0;
    case (shadow_step)
      STEP_PAGE_SEL: b.out_byte = CMD_PAGE_BASE + 8'(shadow_page);
      STEP_COL_HIGH: b.out_byte = CMD_COL_HIGH;
      STEP_COL_LOW:  b.out_byte = CMD_COL_LOW;
      default: begin
        col         = int'(shadow_step) - HEADER_LEN;
        b.is_data   = 1'b1;
        b.out_byte  = shadow_store[int'(shadow_page) * COLUMNS + col];
        b.frame_end = (col == COLUMNS - 1) && (int'(shadow_page) == PAGES - 1);
      end
    endcase
    if (int'(shadow_step) == HEADER_LEN + COLUMNS - 1) begin
      shadow_step = '0;
      shadow_page = (int'(shadow_page) == PAGES - 1) ? '0 : shadow_page + 1'b1;
    end else begin
      shadow_step = shadow_step + 1'b1;
    end
    return b;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    int          idx;
    logic [7:0]  bit_mask;
    panel_byte_t want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
      shadow_page = '0;
      shadow_step = '0;
      panel_bytes_due.delete();
      mismatches = 0;
    end else begin
      // Apply the accepted input word: draws update the shadow, refreshes queue a byte.
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_DRAW) begin
          idx      = int'(s_axis_tdata[12:10]) * COLUMNS + int'(s_axis_tdata[6:0]);
          bit_mask = 8'h01 << s_axis_tdata[9:7];
          if (s_axis_tdata[13]) shadow_store[idx] = shadow_store[idx] | bit_mask;
          else                  shadow_store[idx] = shadow_store[idx] & ~bit_mask;
        end else begin
          panel_bytes_due.push_back(next_panel_byte());
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (panel_bytes_due.size() == 0) begin
          mismatches++;
          $display("%0t: output word with nothing due: is_data %0b byte %02h frame_end %0b",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end else begin
          want = panel_bytes_due.pop_front();
          if (m_axis_tuser !== want.is_data) begin
            mismatches++;
            $display("%0t: is_data expected %0b, got %0b", $time, want.is_data, m_axis_tuser);
          end
          if (m_axis_tdata !== want.out_byte) begin
            mismatches++;
            $display("%0t: out_byte expected %02h, got %02h", $time, want.out_byte,
                     m_axis_tdata);
          end
          if (m_axis_tlast !== want.frame_end) begin
            mismatches++;
            $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end,
                     m_axis_tlast);
          end
        end
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_cnt_o  <= panel_bytes_due.size();
  end

endmodule

FILE: tb/sv/tb_page_framebuffer_refresh.sv
`timescale 1ns / 1ps
// Testbench top for the page framebuffer refresh block: stimulus, watchdog and verdict.
module tb_page_framebuffer_refresh;
  import pfr_pkg::*;

  // Idle limit covers the clearing pass after reset plus any stall.
  localparam int IDLE_LIMIT    = 4000;
  localparam int ITEM_TARGET   = 950;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PAGE_STEPS    = HEADER_LEN + COLUMNS;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // x [6:0], y [12:7], pixel_on [13], zero pad
  logic        s_axis_tuser  = 1'b0; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // out_byte [7:0]
  logic        m_axis_tuser;         // is_data
  logic        m_axis_tlast;         // frame_end

  int mismatch_cnt;
  int pending_cnt;
  int words_sent;
  int refreshes_sent;
  int idle_cycles;

  always #6 clk_i = ~clk_i;

  page_framebuffer_refresh uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  pfr_stream_scoreboard scoreboard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  // Receiver back-pressure: pick a new stall mode each time the phase counter wraps.
  // Mode 0 never stalls, 1 stalls half the time, 2 accepts one cycle in four,
  // 3 holds ready low for long runs.
  always @(negedge clk_i) begin : sink_stall
    int unsigned phase;
    int unsigned mode;
    int unsigned hold;
    if (phase == 0) mode = $urandom_range(0, 3);
    phase = (phase + 1) % 64;
    case (mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (hold == 0) hold = $urandom_range(1, 20);
        hold--;
        m_axis_tready <= (hold == 0);
      end
    endcase
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Present one word at the falling edge and hold it until the block takes it.
  task automatic send_word(input op_e op, input logic [6:0] x, input logic [5:0] y,
                           input logic on);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, on, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (op == OP_REFRESH) refreshes_sent++;
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic send_refreshes(input int n);
    repeat (n) send_word(OP_REFRESH, 7'($urandom), 6'($urandom), 1'($urandom));
  endtask

  // Draw aimed at the column about to go out, so that reads land right after writes.
  task automatic draw_near_refresh();
    int         step;
    logic [2:0] page;
    logic [6:0] col;
    step = refreshes_sent % PAGE_STEPS;
    page = 3'((refreshes_sent / PAGE_STEPS) % PAGES);
    col  = (step < HEADER_LEN) ? 7'd0 : 7'(step - HEADER_LEN);
    send_word(OP_DRAW, col + 7'($urandom_range(0, 3)), {page, 3'($urandom)},
              ($urandom_range(0, 3) != 0));
  endtask

  initial begin : stimulus
    int burst_len;
    words_sent     = 0;
    refreshes_sent = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: header of page 0, corner pixels, set then clear, a draw right
    // before its byte is read, and draws between refreshes leave the position alone.
    send_refreshes(3);
    send_word(OP_DRAW, 7'd0,   6'd0,  1'b1);
    send_word(OP_DRAW, 7'd127, 6'd63, 1'b1);
    send_word(OP_DRAW, 7'd127, 6'd0,  1'b1);
    send_word(OP_DRAW, 7'd0,   6'd63, 1'b1);
    send_word(OP_DRAW, 7'd85,  6'd42, 1'b1);
    send_word(OP_DRAW, 7'd42,  6'd21, 1'b1);
    send_word(OP_DRAW, 7'd1,   6'd7,  1'b1);
    send_word(OP_DRAW, 7'd1,   6'd7,  1'b0);
    send_refreshes(2);
    send_word(OP_DRAW, 7'd2,   6'd5,  1'b1);
    send_refreshes(1);
    send_word(OP_DRAW, 7'd3,   6'd2,  1'b1);
    send_word(OP_DRAW, 7'd3,   6'd6,  1'b1);
    send_refreshes(2);
    hold_off(3);

    // Random: mostly refreshes, draws split between random pixels and the
    // bytes about to be streamed; bursts with gaps, some back to back.
    while (words_sent < ITEM_TARGET) begin
      burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (burst_len) begin
        if ($urandom_range(0, 3) != 0)      send_refreshes(1);
        else if ($urandom_range(0, 1) == 0) draw_near_refresh();
        else send_word(OP_DRAW, 7'($urandom), 6'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end
    hold_off(1);

    // Drain: wait for every due byte, then let the pipeline settle.
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
